// ===== rtl/atls_pkg.sv =====
// shared types, constants and constant-divisor helpers for the tri-level slicer
// no dependencies; imported by atls_update and adaptive_tri_level_slicer

package atls_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int FRAC_BITS   = 8;
  localparam int FIX_BITS    = SAMPLE_BITS + FRAC_BITS;

  // update constants
  localparam int SLOW_KEEP   = 99;   // slow average: 99 parts old, 1 part new
  localparam int SLOW_DIV    = 100;
  localparam int FAST_GAIN   = 9;    // fast attack: 1 part old, 9 parts new
  localparam int FAST_DIV    = 10;
  localparam int DEV_MIN     = 1;    // mean tracks deviations above this
  localparam int ENV_DEV_MIN = 10;   // envelope decays only on deviations above this
  localparam int HS_FLOOR    = 2;

  // reciprocal for numerators below 100 * 2^FIX_BITS
  localparam int N100_W  = FIX_BITS + 7;
  localparam int K100    = N100_W + 7;
  localparam longint unsigned M100 = ((64'd1 << K100) + SLOW_DIV - 1) / SLOW_DIV;
  localparam int M100_W  = $clog2(M100 + 1);
  localparam int P100_W  = N100_W + M100_W;

  // reciprocal for numerators below 10 * 2^FIX_BITS
  localparam int N10_W   = FIX_BITS + 4;
  localparam int K10     = N10_W + 4;
  localparam longint unsigned M10 = ((64'd1 << K10) + FAST_DIV - 1) / FAST_DIV;
  localparam int M10_W   = $clog2(M10 + 1);
  localparam int P10_W   = N10_W + M10_W;

  typedef logic [FIX_BITS-1:0]    fix_t;
  typedef logic [SAMPLE_BITS-1:0] smp_t;

  typedef enum logic [1:0] {
    LVL_INSIDE = 2'd0,
    LVL_LOW    = 2'd1,
    LVL_HIGH   = 2'd2
  } level_t;

  typedef struct packed {
    fix_t center;
    fix_t mean;
    fix_t env;
    logic floor_fixed;   // floor held at the high-speed value
  } atls_state_t;

  function automatic fix_t div100(input logic [N100_W-1:0] num);
    logic [P100_W-1:0] prod;
    prod = P100_W'(num) * P100_W'(M100);
    return prod[K100 +: FIX_BITS];
  endfunction

  function automatic fix_t div10(input logic [N10_W-1:0] num);
    logic [P10_W-1:0] prod;
    prod = P10_W'(num) * P10_W'(M10);
    return prod[K10 +: FIX_BITS];
  endfunction

endpackage

// ===== rtl/atls_update.sv =====
// classification and next-state logic for one sample of the tri-level slicer
// depends on atls_pkg

module atls_update import atls_pkg::*; (
  input  atls_state_t state,
  input  smp_t        sample,
  input  logic        calibrate,
  input  logic        high_speed,
  output atls_state_t state_nxt,
  output level_t      level
);

  logic [FIX_BITS:0]   floor_sum;
  smp_t                floor_cur;
  fix_t                s_fix;
  fix_t                f_fix;
  logic [FIX_BITS:0]   lo_sum;
  logic [FIX_BITS:0]   hi_sum;
  fix_t                diff;
  smp_t                dev;
  fix_t                devq;
  logic [N100_W-1:0]   num_a;
  logic [N100_W-1:0]   num_env_slow;
  logic [N10_W-1:0]    num_env_fast;
  fix_t                q_a;
  fix_t                q_env_slow;
  fix_t                q_env_fast;

  // floor follows the mean and envelope unless high-speed mode pinned it
  assign floor_sum = (FIX_BITS+1)'(state.mean) + (FIX_BITS+1)'(state.env);
  assign floor_cur = state.floor_fixed ? SAMPLE_BITS'(HS_FLOOR)
                                       : floor_sum[FIX_BITS:FRAC_BITS+1];

  assign s_fix  = {sample, FRAC_BITS'(0)};
  assign f_fix  = {floor_cur, FRAC_BITS'(0)};
  assign lo_sum = (FIX_BITS+1)'(s_fix) + (FIX_BITS+1)'(f_fix);
  assign hi_sum = (FIX_BITS+1)'(state.center) + (FIX_BITS+1)'(f_fix);

  always_comb begin
    if (lo_sum < (FIX_BITS+1)'(state.center)) begin
      level = LVL_LOW;
    end else if ((FIX_BITS+1)'(s_fix) > hi_sum) begin
      level = LVL_HIGH;
    end else begin
      level = LVL_INSIDE;
    end
  end

  assign diff = (s_fix >= state.center) ? (s_fix - state.center) : (state.center - s_fix);
  assign dev  = diff[FIX_BITS-1:FRAC_BITS];
  assign devq = {dev, FRAC_BITS'(0)};

  // one divide-by-100 shared between center calibration and mean tracking
  assign num_a = calibrate
               ? N100_W'(state.center) * N100_W'(SLOW_KEEP) + N100_W'(s_fix)
               : N100_W'(state.mean) * N100_W'(SLOW_KEEP) + N100_W'(devq);
  assign num_env_slow = N100_W'(state.env) * N100_W'(SLOW_KEEP) + N100_W'(devq);
  assign num_env_fast = N10_W'(state.env) + N10_W'(devq) * N10_W'(FAST_GAIN);

  assign q_a        = div100(num_a);
  assign q_env_slow = div100(num_env_slow);
  assign q_env_fast = div10(num_env_fast);

  always_comb begin
    state_nxt = state;
    if (calibrate) begin
      state_nxt.center = q_a;
    end else if (high_speed) begin
      state_nxt.floor_fixed = 1'b1;
    end else begin
      state_nxt.floor_fixed = 1'b0;
      if (dev > SAMPLE_BITS'(DEV_MIN)) begin
        state_nxt.mean = q_a;
      end
      if (devq > state.env) begin
        state_nxt.env = q_env_fast;
      end else if (dev > SAMPLE_BITS'(ENV_DEV_MIN)) begin
        state_nxt.env = q_env_slow;
      end
    end
  end

endmodule

// ===== rtl/adaptive_tri_level_slicer.sv =====
// top level of the adaptive tri-level slicer: input register, update logic, result register
// depends on atls_pkg and atls_update
//
// Usage:
//   in_*  : one converter sample word per handshake (in_valid / in_stall).
//           in_calibrate = 1 nudges the center level toward the sample and
//           produces no result word; 0 classifies the sample.
//   out_* : one level code word per classified sample (out_valid / out_stall).
//   cfg_* : high_speed_mode register, written when cfg_valid and cfg_ready;
//           cfg_ready is always high. Write only while the block is idle.
// Path: a classify word is held in the input register, then its code is registered into out_*.
// Throughput: one word per cycle unless out_stall holds a result. The center,
// mean and envelope updates are finished in the cycle a word leaves the input
// register, so the next word sees the new state directly.
// Stall: when out_stall holds a result, a waiting classify word stays in the
// input register and in_stall rises; calibrate words still pass.
// Reset (rst_n low, synchronous): center at mid-scale, mean, envelope and
// floor at zero, high-speed mode off, both registers empty.

module adaptive_tri_level_slicer import atls_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] in_adc_sample,
  input  logic                   in_calibrate,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             out_level_code,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_high_speed_mode
);

  logic        in_vld_r;
  logic        in_vld_nxt;
  smp_t        smp_r;
  logic        cal_r;
  logic        out_vld_r;
  logic        out_vld_nxt;
  level_t      level_r;
  level_t      level_cur;
  logic        hs_r;
  atls_state_t state_r;
  atls_state_t state_nxt;
  logic        out_free;
  logic        go;
  logic        in_acc;

  assign cfg_ready = 1'b1;

  assign out_free   = !out_vld_r || !out_stall;
  assign go         = in_vld_r && (cal_r || out_free);
  assign in_stall   = in_vld_r && !go;
  assign in_acc     = in_valid && !in_stall;
  assign in_vld_nxt = in_acc || (in_vld_r && !go);
  assign out_vld_nxt = (go && !cal_r) || (out_vld_r && out_stall);

  atls_update u_update (
    .state      (state_r),
    .sample     (smp_r),
    .calibrate  (cal_r),
    .high_speed (hs_r),
    .state_nxt  (state_nxt),
    .level      (level_cur)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      hs_r      <= 1'b0;
      state_r.center      <= fix_t'(1) << (FIX_BITS - 1);
      state_r.mean        <= '0;
      state_r.env         <= '0;
      state_r.floor_fixed <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_valid && cfg_ready) begin
        hs_r <= cfg_high_speed_mode;
      end
      if (go) begin
        state_r <= state_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      smp_r <= in_adc_sample;
      cal_r <= in_calibrate;
    end
    if (go && !cal_r) begin
      level_r <= level_cur;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_level_code = level_r;

endmodule

// ===== verif/tb_top.sv =====
// testbench for adaptive_tri_level_slicer: queue-fed driver, clocked monitor, bit-true predictor
// depends on atls_pkg and the rtl of adaptive_tri_level_slicer; reads no files

`timescale 1ns / 1ps

module tb_top;
  import atls_pkg::*;

  localparam int DRAIN_PAUSE = 4;       // cycles after the last word before touching the register
  localparam int DRAIN_GUARD = 20000;
  localparam longint TIMEOUT_NS = 2_000_000;

  typedef struct {
    smp_t sample;
    logic cal;
  } sample_word_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  smp_t       in_adc_sample = '0;
  logic       in_calibrate = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_level_code;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_high_speed_mode = 1'b0;

  sample_word_t pending_words[$];
  level_t       level_due[$];
  int           send_idle_pct = 16;
  int           recv_idle_pct = 54;
  int           fail_cnt = 0;

  // predictor state
  fix_t center_q = fix_t'(1) << (FIX_BITS - 1);
  fix_t mean_q = '0;
  fix_t env_q = '0;
  smp_t floor_q = '0;
  logic fast_mode = 1'b0;

  adaptive_tri_level_slicer DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_adc_sample       (in_adc_sample),
    .in_calibrate        (in_calibrate),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_level_code      (out_level_code),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_high_speed_mode (cfg_high_speed_mode)
  );

  always #6 clk = ~clk;

  function automatic void note_failure(input string msg);
    if (fail_cnt < 10) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
    fail_cnt++;
  endfunction

  // advance the slicer state by one accepted word, queue the level code if one is due
  function automatic void slice_and_track(input smp_t smp, input logic cal);
    logic [39:0] s_q;
    logic [39:0] fl_q;
    logic [39:0] diff_q;
    logic [39:0] dev;
    logic [39:0] devq;
    level_t code;
    s_q = 40'(smp) << FRAC_BITS;
    if (cal) begin
      center_q = fix_t'((SLOW_KEEP * 40'(center_q) + s_q) / SLOW_DIV);
      return;
    end
    fl_q = 40'(floor_q) << FRAC_BITS;
    if (s_q + fl_q < 40'(center_q)) begin
      code = LVL_LOW;
    end else if (s_q > 40'(center_q) + fl_q) begin
      code = LVL_HIGH;
    end else begin
      code = LVL_INSIDE;
    end
    level_due.push_back(code);
    if (fast_mode) begin
      floor_q = smp_t'(HS_FLOOR);
      return;
    end
    diff_q = (s_q >= 40'(center_q)) ? s_q - 40'(center_q) : 40'(center_q) - s_q;
    dev = diff_q >> FRAC_BITS;
    devq = dev << FRAC_BITS;
    if (dev > DEV_MIN) begin
      mean_q = fix_t'((SLOW_KEEP * 40'(mean_q) + devq) / SLOW_DIV);
    end
    if (devq > 40'(env_q)) begin
      env_q = fix_t'((40'(env_q) + FAST_GAIN * devq) / FAST_DIV);
    end else if (dev > ENV_DEV_MIN) begin
      env_q = fix_t'((SLOW_KEEP * 40'(env_q) + devq) / SLOW_DIV);
    end
    floor_q = smp_t'(((40'(mean_q) + 40'(env_q)) / 2) >> FRAC_BITS);
  endfunction

  // driver: holds a stalled word, otherwise presents the next one or idles
  always @(posedge clk) begin : drive
    sample_word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        slice_and_track(in_adc_sample, in_calibrate);
      end
      if (in_valid && in_stall) begin
        // payload stays put
      end else if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        w = pending_words.pop_front();
        in_valid <= 1'b1;
        in_adc_sample <= w.sample;
        in_calibrate <= w.cal;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: compares each accepted level code with the oldest prediction
  always @(posedge clk) begin : watch
    level_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (level_due.size() == 0) begin
          note_failure($sformatf("level code %0d with no word pending", out_level_code));
        end else begin
          want = level_due.pop_front();
          if (out_level_code !== want) begin
            note_failure($sformatf("level code: expected %0d, got %0d", want, out_level_code));
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic queue_word(input int smp, input logic cal);
    sample_word_t w;
    w.sample = smp_t'(smp);
    w.cal = cal;
    pending_words.push_back(w);
  endtask

  task automatic write_mode(input logic m);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_high_speed_mode <= m;
    do @(posedge clk); while (!cfg_ready);
    fast_mode = m;
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    int guard;
    guard = 0;
    while (pending_words.size() != 0 || in_valid) @(posedge clk);
    while (level_due.size() != 0 && guard < DRAIN_GUARD) begin
      @(posedge clk);
      guard++;
    end
    if (level_due.size() != 0) begin
      note_failure($sformatf("%0d level codes never arrived", level_due.size()));
      level_due.delete();
    end
    // calibrate words leave no trace on the output
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  task automatic add_random_words(input int n);
    int pick;
    int smp;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        // calibrate, mostly near mid-scale so the band stays reachable
        smp = ($urandom_range(3) == 0) ? $urandom_range(4095) : 1848 + $urandom_range(400);
        queue_word(smp, 1'b1);
      end else if (pick < 75) begin
        smp = 2008 + $urandom_range(80);
        queue_word(smp, 1'b0);
      end else begin
        queue_word($urandom_range(4095), 1'b0);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    write_mode(1'b0);

    // tracking mode: tiny, mid-size and full-scale deviations, envelope attack and decay, center calibration
    queue_word(2048, 1'b0);
    queue_word(2049, 1'b0);
    queue_word(2047, 1'b0);
    queue_word(4095, 1'b0);
    queue_word(0, 1'b0);
    queue_word(2050, 1'b0);
    queue_word(2060, 1'b0);
    queue_word(2100, 1'b0);
    queue_word(1990, 1'b0);
    queue_word(4095, 1'b1);
    queue_word(4095, 1'b1);
    queue_word(0, 1'b1);
    queue_word(2048, 1'b0);
    queue_word(2200, 1'b0);
    wait_idle();

    write_mode(1'b1);
    queue_word(4095, 1'b0);
    queue_word(0, 1'b0);
    queue_word(2050, 1'b0);
    queue_word(2051, 1'b0);
    queue_word(2045, 1'b0);
    queue_word(3000, 1'b1);
    queue_word(2060, 1'b0);
    wait_idle();

    write_mode(1'b0);
    queue_word(2048, 1'b0);
    queue_word(2049, 1'b0);
    queue_word(1000, 1'b0);
    wait_idle();

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          send_idle_pct = 16;
          recv_idle_pct = 54;
        end
        1: begin
          send_idle_pct = 54;
          recv_idle_pct = 16;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_mode(1'b0);
      add_random_words(350);
      wait_idle();
      write_mode(1'b1);
      add_random_words(120);
      wait_idle();
    end

    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #TIMEOUT_NS;
    $display("Verification failed");
    $finish;
  end

endmodule
